FILE: sv/assert_macros.svh
// assert_macros.svh: shorthand for clocked assertions in the quaternion unit checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define QR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle rule violated");

// Next-cycle implication
`define QR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle rule violated");

`endif

FILE: sv/qrot_pkg.sv
// qrot_pkg: opcodes, default widths and Hamilton product sign table
// shared by the quaternion unit modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qrot_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int LANES          = 4;

    typedef enum logic [1:0] {
        OP_PRODUCT = 2'd0,
        OP_ROTATE  = 2'd1,
        OP_CONJ    = 2'd2
    } qrot_op_t;

    // Term j of component i is a[j] * b[i ^ j]; bit LANES*i+j set means subtract
    localparam logic [LANES*LANES-1:0] HP_NEG = 16'b0100_0010_1000_1110;

    // Sign table for a * b, or for a * conj(b) (vector part of b negated)
    function automatic logic [LANES*LANES-1:0] hp_neg_mask(input logic conj_b);
        logic [LANES*LANES-1:0] mask;
        int i;
        int j;
        mask = HP_NEG;
        for (i = 0; i < LANES; i++)
        begin
            for (j = 0; j < LANES; j++)
            begin
                if (conj_b && ((i ^ j) != 0))
                begin
                    mask[LANES*i+j] = ~mask[LANES*i+j];
                end
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

FILE: sv/quaternion_rotate_unit.sv
// quaternion_rotate_unit: four-stage pipelined fixed-point quaternion unit
// (product, vector rotation, conjugate). Depends on qrot_pkg, qrot_mul, qrot_rsum.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    opcode, first_w..first_z, second_w..second_z
//   output    out_valid / out_stall  out_w, out_x, out_y, out_z, saturated
//
// One request enters per cycle while in_stall is low.
// The stages are: products of q and the second operand, round and clip of the
// first product, products of that result with conj(q), round and clip again.
// rst_n clears the stage valid bits only; the datapath is not reset.
// out_stall on a waiting result freezes every stage and raises in_stall.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rotate_unit
    import qrot_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic signed [COMPONENT_WIDTH-1:0] first_w,
    input  logic signed [COMPONENT_WIDTH-1:0] first_x,
    input  logic signed [COMPONENT_WIDTH-1:0] first_y,
    input  logic signed [COMPONENT_WIDTH-1:0] first_z,
    input  logic signed [COMPONENT_WIDTH-1:0] second_w,
    input  logic signed [COMPONENT_WIDTH-1:0] second_x,
    input  logic signed [COMPONENT_WIDTH-1:0] second_y,
    input  logic signed [COMPONENT_WIDTH-1:0] second_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COMPONENT_WIDTH-1:0] out_w,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic                              saturated
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int PW = 2 * COMPONENT_WIDTH;
    localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MAXW = ~MINW;
    localparam logic [LANES*LANES-1:0] NEG_DIRECT = hp_neg_mask(1'b0);
    localparam logic [LANES*LANES-1:0] NEG_CONJ   = hp_neg_mask(1'b1);

    logic               adv;
    logic [3:0]         valid_reg;
    logic [3:0]         valid_next;
    logic [1:0]         op1_reg;
    logic [1:0]         op2_reg;
    logic [1:0]         op3_reg;
    logic [1:0]         op4_reg;
    logic signed [W-1:0] q_in  [LANES];
    logic signed [W-1:0] b_in  [LANES];
    logic signed [W-1:0] q1_reg [LANES];
    logic signed [W-1:0] q2_reg [LANES];
    logic signed [PW-1:0] prod1 [LANES][LANES];
    logic signed [PW-1:0] prod3 [LANES][LANES];
    logic signed [W-1:0] t2    [LANES];
    logic               tsat2;
    logic signed [W-1:0] r4    [LANES];
    logic               rsat4;
    logic signed [W-1:0] alt_next [LANES];
    logic               alt_sat_next;
    logic signed [W-1:0] alt3_reg [LANES];
    logic               alt_sat3_reg;
    logic signed [W-1:0] alt4_reg [LANES];
    logic               alt_sat4_reg;
    logic               rotate_out;

    // Whole pipeline moves unless a finished result is held at the output
    assign adv      = !(valid_reg[3] && out_stall);
    assign in_stall = !adv;

    // Operand vectors; rotate takes the vector as a pure quaternion
    assign q_in[0] = first_w;
    assign q_in[1] = first_x;
    assign q_in[2] = first_y;
    assign q_in[3] = first_z;
    assign b_in[0] = (opcode == OP_ROTATE) ? '0 : second_w;
    assign b_in[1] = second_x;
    assign b_in[2] = second_y;
    assign b_in[3] = second_z;

    // Valid bits
    assign valid_next = {valid_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Side-band: opcode, first quaternion and the stage-2 alternate results follow the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg      <= opcode;
            op2_reg      <= op1_reg;
            op3_reg      <= op2_reg;
            op4_reg      <= op3_reg;
            q1_reg       <= q_in;
            q2_reg       <= q1_reg;
            alt3_reg     <= alt_next;
            alt_sat3_reg <= alt_sat_next;
            alt4_reg     <= alt3_reg;
            alt_sat4_reg <= alt_sat3_reg;
        end
    end

    // Stage 1: q * b
    qrot_mul #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mul1 (
        .clk  (clk),
        .en   (adv),
        .a    (q_in),
        .b    (b_in),
        .prod (prod1)
    );

    // Stage 2: round and clip the first product
    qrot_rsum #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_rsum1 (
        .clk      (clk),
        .en       (adv),
        .prod     (prod1),
        .neg_mask (NEG_DIRECT),
        .res      (t2),
        .sat      (tsat2)
    );

    // Stage 3: t * conj(q)
    qrot_mul #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mul2 (
        .clk  (clk),
        .en   (adv),
        .a    (t2),
        .b    (q2_reg),
        .prod (prod3)
    );

    // Stage 4: round and clip the second product
    qrot_rsum #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_rsum2 (
        .clk      (clk),
        .en       (adv),
        .prod     (prod3),
        .neg_mask (NEG_CONJ),
        .res      (r4),
        .sat      (rsat4)
    );

    // Results that do not need the second product, formed at stage 2
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            alt_next[k] = '0;
        end
        alt_sat_next = 1'b0;
        unique case (op2_reg)
            OP_PRODUCT:
            begin
                alt_next     = t2;
                alt_sat_next = tsat2;
            end
            OP_ROTATE:
            begin
                alt_sat_next = tsat2;
            end
            OP_CONJ:
            begin
                alt_next[0] = q2_reg[0];
                for (int k = 1; k < LANES; k++)
                begin
                    if (q2_reg[k] == MINW)
                    begin
                        alt_next[k]  = MAXW;
                        alt_sat_next = 1'b1;
                    end
                    else
                    begin
                        alt_next[k] = -q2_reg[k];
                    end
                end
            end
            default:
            begin
                alt_sat_next = 1'b0;
            end
        endcase
    end

    // Output selection
    assign rotate_out = (op4_reg == OP_ROTATE);
    assign out_valid  = valid_reg[3];
    assign out_w      = alt4_reg[0];
    assign out_x      = rotate_out ? r4[1] : alt4_reg[1];
    assign out_y      = rotate_out ? r4[2] : alt4_reg[2];
    assign out_z      = rotate_out ? r4[3] : alt4_reg[3];
    assign saturated  = alt_sat4_reg | (rotate_out & rsat4);

endmodule

`default_nettype wire

FILE: sv/qrot_mul.sv
// qrot_mul: registered array of sixteen signed products for one Hamilton product.
// Depends on qrot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrot_mul
    import qrot_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [COMPONENT_WIDTH-1:0]     a [LANES],
    input  logic signed [COMPONENT_WIDTH-1:0]     b [LANES],
    output logic signed [2*COMPONENT_WIDTH-1:0]   prod [LANES][LANES]
);

    localparam int PW = 2 * COMPONENT_WIDTH;

    logic signed [PW-1:0] prod_reg [LANES][LANES];

    // One multiplier per term: component i, term j pairs a[j] with b[i ^ j]
    for (genvar i = 0; i < LANES; i++)
    begin : g_row
        for (genvar j = 0; j < LANES; j++)
        begin : g_term
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[i][j] <= PW'(a[j]) * PW'(b[i ^ j]);
                end
            end
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/qrot_rsum.sv
// qrot_rsum: signed sum of four products per component, round half up,
// saturate to the component range, registered. Depends on qrot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrot_rsum
    import qrot_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [2*COMPONENT_WIDTH-1:0]   prod [LANES][LANES],
    input  logic [LANES*LANES-1:0]                neg_mask,
    output logic signed [COMPONENT_WIDTH-1:0]     res [LANES],
    output logic                                  sat
);

    localparam int PW = 2 * COMPONENT_WIDTH;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COMPONENT_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    logic signed [SW-1:0]              acc    [LANES];
    logic signed [SW-1:0]              scaled [LANES];
    logic signed [COMPONENT_WIDTH-1:0] res_next [LANES];
    logic [LANES-1:0]                  clip_next;
    logic signed [COMPONENT_WIDTH-1:0] res_reg [LANES];
    logic                              sat_reg;

    // Exact signed sum plus half an LSB, floor shift, clip
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            acc[i] = HALF;
            for (int j = 0; j < LANES; j++)
            begin
                if (neg_mask[LANES*i+j])
                begin
                    acc[i] = acc[i] - SW'(prod[i][j]);
                end
                else
                begin
                    acc[i] = acc[i] + SW'(prod[i][j]);
                end
            end
            scaled[i] = acc[i] >>> FRACTION_BITS;
            if (scaled[i] > MAXV)
            begin
                res_next[i]  = MAXV[COMPONENT_WIDTH-1:0];
                clip_next[i] = 1'b1;
            end
            else if (scaled[i] < MINV)
            begin
                res_next[i]  = MINV[COMPONENT_WIDTH-1:0];
                clip_next[i] = 1'b1;
            end
            else
            begin
                res_next[i]  = scaled[i][COMPONENT_WIDTH-1:0];
                clip_next[i] = 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= |clip_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

FILE: sv/qrot_checker.sv
// qrot_checker: port-level assertions for quaternion_rotate_unit, bound to it.
// Depends on assert_macros.svh and qrot_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qrot_checker
    import qrot_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [COMPONENT_WIDTH-1:0] out_x,
    input logic                              saturated
);

    logic out_held;

    assign out_held = out_valid && out_stall;

    // A held result stays valid, and its out_x and saturated stay unchanged
    `QR_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
    `QR_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall, $stable(out_x) && $stable(saturated))

    // Input is blocked only by a held result, and always flows when it drains
    `QR_ASSERT_NOW(a_stall_only_when_held, in_stall, out_held)
    `QR_ASSERT_NOW(a_flow_when_drained, in_valid && !out_held, !in_stall)

endmodule

bind quaternion_rotate_unit qrot_checker #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qrot_checker (.*);

`default_nettype wire
